// ----- rtl/depth_to_range_image_assert.svh -----
// Assertion macros shared by the depth-to-range image block.
`ifndef DEPTH_TO_RANGE_IMAGE_ASSERT_SVH
`define DEPTH_TO_RANGE_IMAGE_ASSERT_SVH
`ifndef SYNTHESIS
`define DTR_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("depth_to_range_image: check failed");
`define DTR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("depth_to_range_image: check failed");
`else
`define DTR_ASSERT(lbl, ante, cons)
`define DTR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/dtr_pkg.sv -----
// Shared types and constants of the depth-to-range image block.
package dtr_pkg;

    localparam int SIZE_W     = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int SQRT_STEPS = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_Y  = 3'd5;

    localparam logic [11:0] RST_WIDTH    = 12'd640;
    localparam logic [11:0] RST_HEIGHT   = 12'd480;
    localparam logic [15:0] RST_CENTER_X = 16'd5120;
    localparam logic [15:0] RST_CENTER_Y = 16'd3840;
    localparam logic [31:0] RST_INV_FX   = 32'd8589934;
    localparam logic [31:0] RST_INV_FY   = 32'd8589934;

    localparam logic [19:0]        RANGE_ONES = 20'hFFFFF;
    localparam logic signed [19:0] XY_MAX     = 20'sh7FFFF;
    localparam logic signed [19:0] XY_MIN     = 20'sh80000;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_DEPTH_X,
        MUL_INV_X,
        MUL_DEPTH_Y,
        MUL_INV_Y,
        MUL_SQ_X,
        MUL_SQ_Y,
        MUL_SQ_Z
    } t_mul_op;

    typedef struct packed {
        logic    accept;
        t_mul_op mul_op;
        logic    take_x;
        logic    take_y;
        logic    acc_load;
        logic    acc_add;
        logic    sqrt_init;
        logic    sqrt_step;
        logic    finish;
    } t_cmd;

endpackage

// ----- rtl/depth_to_range_image.sv -----
// Depth-to-range image top level: one depth word in, one back-projected point word out.
// The depth word steps through the multiply states, square-root init, the square-root steps and FIN;
// a new word is taken only once the last has left FIN, as the shared 32x32 multiplier (seven products)
// and the one-bit-per-cycle square root (20 steps) in the datapath serve one word at a time.
// A finished word waits in the output register while the next depth word is taken.
// Synchronous active-low reset restores default registers, clears counters and resets the extremes.
module depth_to_range_image #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [15:0]                   i_depth_mm,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [19:0]            o_point_x,
    output logic signed [19:0]            o_point_y,
    output logic [15:0]                   o_point_z,
    output logic [19:0]                   o_range_mm,
    output logic [10:0]                   o_pixel_column,
    output logic [10:0]                   o_pixel_row,
    output logic                          o_frame_last,
    output logic [19:0]                   o_min_range_so_far,
    output logic [19:0]                   o_max_range_so_far,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dtr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);
    import dtr_pkg::*;

    t_cmd cmd;
    logic in_acc;

    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_valid && o_ready;

    dtr_control u_control (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd)
    );

    dtr_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_depth_mm         (i_depth_mm),
        .i_cfg_we           (i_cfg_valid && o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_point_x          (o_point_x),
        .o_point_y          (o_point_y),
        .o_point_z          (o_point_z),
        .o_range_mm         (o_range_mm),
        .o_pixel_column     (o_pixel_column),
        .o_pixel_row        (o_pixel_row),
        .o_frame_last       (o_frame_last),
        .o_min_range_so_far (o_min_range_so_far),
        .o_max_range_so_far (o_max_range_so_far)
    );

    // The range of a point can never fall below its depth, and the extremes bracket it.
`include "depth_to_range_image_assert.svh"
    `DTR_ASSERT_NEXT(a_busy_after_accept, in_acc, !o_ready)
    `DTR_ASSERT(a_range_covers_depth, o_valid, o_range_mm >= 20'(o_point_z))
    `DTR_ASSERT(a_min_le_range, o_valid, o_min_range_so_far <= o_range_mm)
    `DTR_ASSERT(a_range_le_max, o_valid, o_range_mm <= o_max_range_so_far)
endmodule

// ----- rtl/dtr_control.sv -----
// Sequencer that steps one pixel through the shared multiplier and square root.
module dtr_control (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    output logic         o_valid,
    input  logic         i_ready,
    output dtr_pkg::t_cmd o_cmd
);
    import dtr_pkg::*;

    localparam int CNT_W = $clog2(SQRT_STEPS);

    typedef enum logic [3:0] {
        ST_IDLE, ST_MDX, ST_MIX, ST_MDY, ST_MIY, ST_SQX, ST_SQY, ST_SQZ,
        ST_SINIT, ST_SQRT, ST_FIN
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_out_valid;
    logic             fin_load;

    assign o_ready  = (r_state == ST_IDLE);
    assign o_valid  = r_out_valid;
    assign fin_load = (r_state == ST_FIN) && (!r_out_valid || i_ready);

    always_comb begin
        o_cmd = '0;
        o_cmd.mul_op = MUL_NONE;
        unique case (r_state)
            ST_IDLE:  o_cmd.accept = i_valid;
            ST_MDX:   o_cmd.mul_op = MUL_DEPTH_X;
            ST_MIX:   o_cmd.mul_op = MUL_INV_X;
            ST_MDY: begin
                o_cmd.mul_op = MUL_DEPTH_Y;
                o_cmd.take_x = 1'b1;
            end
            ST_MIY:   o_cmd.mul_op = MUL_INV_Y;
            ST_SQX: begin
                o_cmd.mul_op = MUL_SQ_X;
                o_cmd.take_y = 1'b1;
            end
            ST_SQY: begin
                o_cmd.mul_op   = MUL_SQ_Y;
                o_cmd.acc_load = 1'b1;
            end
            ST_SQZ: begin
                o_cmd.mul_op  = MUL_SQ_Z;
                o_cmd.acc_add = 1'b1;
            end
            ST_SINIT: o_cmd.sqrt_init = 1'b1;
            ST_SQRT:  o_cmd.sqrt_step = 1'b1;
            ST_FIN:   o_cmd.finish = fin_load;
            default:  o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fin_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE:  if (i_valid) r_state <= ST_MDX;
                ST_MDX:   r_state <= ST_MIX;
                ST_MIX:   r_state <= ST_MDY;
                ST_MDY:   r_state <= ST_MIY;
                ST_MIY:   r_state <= ST_SQX;
                ST_SQX:   r_state <= ST_SQY;
                ST_SQY:   r_state <= ST_SQZ;
                ST_SQZ:   r_state <= ST_SINIT;
                ST_SINIT: begin
                    r_cnt   <= '0;
                    r_state <= ST_SQRT;
                end
                ST_SQRT: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(SQRT_STEPS - 1)) r_state <= ST_FIN;
                end
                ST_FIN:   if (fin_load) r_state <= ST_IDLE;
                default:  r_state <= ST_IDLE;
            endcase
        end
    end
endmodule

// ----- rtl/dtr_datapath.sv -----
// Datapath: registers, raster counters, shared multiplier, square root and output word.
module dtr_datapath #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dtr_pkg::t_cmd                  i_cmd,
    input  logic [15:0]                    i_depth_mm,
    input  logic                           i_cfg_we,
    input  logic [dtr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    output logic signed [19:0]             o_point_x,
    output logic signed [19:0]             o_point_y,
    output logic [15:0]                    o_point_z,
    output logic [19:0]                    o_range_mm,
    output logic [10:0]                    o_pixel_column,
    output logic [10:0]                    o_pixel_row,
    output logic                           o_frame_last,
    output logic [19:0]                    o_min_range_so_far,
    output logic [19:0]                    o_max_range_so_far
);
    import dtr_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam logic [SIZE_W-1:0] MAX_W = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] MAX_H = SIZE_W'(MAX_HEIGHT);

    logic [11:0] r_width, r_height;
    logic [15:0] r_cx, r_cy;
    logic [31:0] r_ifx, r_ify;

    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [19:0]   r_min, r_max;

    logic [15:0]        r_depth;
    logic [63:0]        r_prod;
    logic signed [19:0] r_px, r_py;
    logic [39:0]        r_acc, r_rad;
    logic [22:0]        r_rem;
    logic [19:0]        r_root;

    logic [SIZE_W-1:0] w_ext, h_ext, eff_w, eff_h, col_ext, row_ext;
    logic              row_end, last;
    logic signed [19:0] diff_x, diff_y;
    logic [18:0]       mag_x, mag_y;
    logic [19:0]       ax, ay;
    logic [31:0]       prod_sat, mul_a, mul_b;
    logic [22:0]       rem_sh, trial;
    logic [19:0]       new_min, new_max;

    // Floor of prod / 2^36 with the sign applied, clamped to 20 signed bits.
    function automatic logic signed [19:0] project_q(input logic [63:0] prod,
                                                     input logic neg);
        logic [28:0] qn;
        qn = {1'b0, prod[63:36]} + 29'(prod[35:0] != 36'd0);
        if (neg) begin
            if (qn > 29'd524288) return XY_MIN;
            return 20'(-qn);
        end
        if (prod[63:36] > 28'd524287) return XY_MAX;
        return 20'(prod[63:36]);
    endfunction

    always_comb begin
        w_ext = SIZE_W'(r_width);
        h_ext = SIZE_W'(r_height);
        priority if (w_ext == '0) eff_w = SIZE_W'(1);
        else if (w_ext > MAX_W)   eff_w = MAX_W;
        else                      eff_w = w_ext;
        priority if (h_ext == '0) eff_h = SIZE_W'(1);
        else if (h_ext > MAX_H)   eff_h = MAX_H;
        else                      eff_h = h_ext;
    end

    assign col_ext = SIZE_W'(r_col);
    assign row_ext = SIZE_W'(r_row);
    assign row_end = (col_ext + 1'b1) >= eff_w;
    assign last    = row_end && ((row_ext + 1'b1) >= eff_h);

    assign diff_x = $signed({2'b00, col_ext, 4'b0000}) - $signed({4'b0000, r_cx});
    assign diff_y = $signed({2'b00, row_ext, 4'b0000}) - $signed({4'b0000, r_cy});
    assign mag_x  = diff_x[19] ? 19'(-diff_x) : 19'(diff_x);
    assign mag_y  = diff_y[19] ? 19'(-diff_y) : 19'(diff_y);
    assign ax     = r_px[19] ? 20'(-r_px) : 20'(r_px);
    assign ay     = r_py[19] ? 20'(-r_py) : 20'(r_py);
    assign prod_sat = (r_prod[63:32] != 32'd0) ? 32'hFFFFFFFF : r_prod[31:0];

    always_comb begin
        unique case (i_cmd.mul_op)
            MUL_DEPTH_X: begin mul_a = 32'(r_depth); mul_b = 32'(mag_x); end
            MUL_INV_X:   begin mul_a = prod_sat;     mul_b = r_ifx;      end
            MUL_DEPTH_Y: begin mul_a = 32'(r_depth); mul_b = 32'(mag_y); end
            MUL_INV_Y:   begin mul_a = prod_sat;     mul_b = r_ify;      end
            MUL_SQ_X:    begin mul_a = 32'(ax);      mul_b = 32'(ax);    end
            MUL_SQ_Y:    begin mul_a = 32'(ay);      mul_b = 32'(ay);    end
            MUL_SQ_Z:    begin mul_a = 32'(r_depth); mul_b = 32'(r_depth); end
            default:     begin mul_a = '0;           mul_b = '0;         end
        endcase
    end

    // One result bit per step of the restoring square root.
    assign rem_sh  = {r_rem[20:0], r_rad[39:38]};
    assign trial   = {1'b0, r_root, 2'b01};
    assign new_min = (r_root < r_min) ? r_root : r_min;
    assign new_max = (r_root > r_max) ? r_root : r_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
            r_cx     <= RST_CENTER_X;
            r_cy     <= RST_CENTER_Y;
            r_ifx    <= RST_INV_FX;
            r_ify    <= RST_INV_FY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data[11:0];
                CFG_IMAGE_HEIGHT: r_height <= i_cfg_data[11:0];
                CFG_CENTER_X:     r_cx     <= i_cfg_data[15:0];
                CFG_CENTER_Y:     r_cy     <= i_cfg_data[15:0];
                CFG_INV_FOCAL_X:  r_ifx    <= i_cfg_data;
                CFG_INV_FOCAL_Y:  r_ify    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_min <= RANGE_ONES;
            r_max <= '0;
        end else if (i_cmd.finish) begin
            priority if (last) begin
                r_col <= '0;
                r_row <= '0;
                r_min <= RANGE_ONES;
                r_max <= '0;
            end else if (row_end) begin
                r_col <= '0;
                r_row <= r_row + 1'b1;
                r_min <= new_min;
                r_max <= new_max;
            end else begin
                r_col <= r_col + 1'b1;
                r_min <= new_min;
                r_max <= new_max;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (i_cmd.accept) r_depth <= i_depth_mm;
        if (i_cmd.take_x) r_px <= project_q(r_prod, diff_x[19]);
        if (i_cmd.take_y) r_py <= project_q(r_prod, diff_y[19]);
        if (i_cmd.acc_load) r_acc <= r_prod[39:0];
        if (i_cmd.acc_add)  r_acc <= r_acc + r_prod[39:0];
        if (i_cmd.sqrt_init) begin
            r_rad  <= r_acc + r_prod[39:0];
            r_rem  <= '0;
            r_root <= '0;
        end
        if (i_cmd.sqrt_step) begin
            r_rad <= {r_rad[37:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[18:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[18:0], 1'b0};
            end
        end
        if (i_cmd.finish) begin
            o_point_x          <= r_px;
            o_point_y          <= r_py;
            o_point_z          <= r_depth;
            o_range_mm         <= r_root;
            o_pixel_column     <= col_ext[10:0];
            o_pixel_row        <= row_ext[10:0];
            o_frame_last       <= last;
            o_min_range_so_far <= new_min;
            o_max_range_so_far <= new_max;
        end
    end
endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for the depth-to-range image block: scoreboard class and stimulus tasks.
module testbench;
    import dtr_pkg::*;

    localparam int IDLE_LIMIT  = 4000;
    localparam int SETTLE_WAIT = 40;

    typedef struct {
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic [15:0]        z;
        logic [19:0]        range_mm;
        logic [10:0]        column;
        logic [10:0]        row;
        logic               last;
        logic [19:0]        near_mm;
        logic [19:0]        far_mm;
    } t_point_word;

    class range_scoreboard;
        logic [11:0] width_reg;
        logic [11:0] height_reg;
        logic [15:0] cx_reg;
        logic [15:0] cy_reg;
        logic [31:0] ifx_reg;
        logic [31:0] ify_reg;
        int unsigned col_count;
        int unsigned row_count;
        logic [19:0] frame_min;
        logic [19:0] frame_max;
        t_point_word pending_points[$];
        int          errors;

        function new();
            width_reg  = RST_WIDTH;
            height_reg = RST_HEIGHT;
            cx_reg     = RST_CENTER_X;
            cy_reg     = RST_CENTER_Y;
            ifx_reg    = RST_INV_FX;
            ify_reg    = RST_INV_FY;
            col_count  = 0;
            row_count  = 0;
            frame_min  = RANGE_ONES;
            frame_max  = '0;
            errors     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                CFG_IMAGE_WIDTH:  width_reg  = data[11:0];
                CFG_IMAGE_HEIGHT: height_reg = data[11:0];
                CFG_CENTER_X:     cx_reg     = data[15:0];
                CFG_CENTER_Y:     cy_reg     = data[15:0];
                CFG_INV_FOCAL_X:  ifx_reg    = data;
                CFG_INV_FOCAL_Y:  ify_reg    = data;
                default: ;
            endcase
        endfunction

        function int unsigned eff_size(logic [11:0] v, int unsigned limit);
            if (v == 0) return 1;
            if (v > limit) return limit;
            return v;
        endfunction

        function logic signed [19:0] back_project(logic [15:0] d, int unsigned pos,
                                                  logic [15:0] c, logic [31:0] inv);
            longint            diff;
            bit                neg;
            longint unsigned   mag;
            longint unsigned   prod;
            longint unsigned   q;
            diff = longint'(pos) * 16 - longint'(c);
            neg  = diff < 0;
            mag  = neg ? longint'(-diff) : longint'(diff);
            prod = longint'(d) * mag;
            if (prod > 64'hFFFF_FFFF) prod = 64'hFFFF_FFFF;
            prod = prod * longint'(inv);
            q    = prod >> 36;
            if (neg) begin
                if ((prod & 64'hF_FFFF_FFFF) != 0) q = q + 1;
                if (q > 524288) return XY_MIN;
                return -20'(q);
            end
            if (q > 524287) return XY_MAX;
            return 20'(q);
        endfunction

        function longint unsigned floor_sqrt(longint unsigned n);
            longint unsigned res;
            longint unsigned bitv;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (n >= res + bitv) begin
                    n   = n - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        function void note_depth(logic [15:0] d);
            t_point_word     p;
            int unsigned     w;
            int unsigned     h;
            longint          ax;
            longint          ay;
            longint unsigned sum;
            bit              row_end;
            w  = eff_size(width_reg, 2048);
            h  = eff_size(height_reg, 2048);
            p.x = back_project(d, col_count, cx_reg, ifx_reg);
            p.y = back_project(d, row_count, cy_reg, ify_reg);
            ax  = p.x < 0 ? -longint'(p.x) : longint'(p.x);
            ay  = p.y < 0 ? -longint'(p.y) : longint'(p.y);
            sum = ax * ax + ay * ay + longint'(d) * longint'(d);
            p.range_mm = 20'(floor_sqrt(sum));
            row_end = (col_count + 1) >= w;
            p.last  = row_end && ((row_count + 1) >= h);
            if (p.range_mm < frame_min) frame_min = p.range_mm;
            if (p.range_mm > frame_max) frame_max = p.range_mm;
            p.z       = d;
            p.column  = 11'(col_count);
            p.row     = 11'(row_count);
            p.near_mm = frame_min;
            p.far_mm  = frame_max;
            pending_points.push_back(p);
            if (p.last) begin
                col_count = 0;
                row_count = 0;
                frame_min = RANGE_ONES;
                frame_max = '0;
            end else if (row_end) begin
                col_count = 0;
                row_count = row_count + 1;
            end else begin
                col_count = col_count + 1;
            end
        endfunction

        function void check_point(t_point_word got);
            t_point_word e;
            if (pending_points.size() == 0) begin
                $display("%0t: unexpected output word, x %0d y %0d", $realtime, got.x, got.y);
                errors++;
                return;
            end
            e = pending_points.pop_front();
            if (got.x !== e.x) begin
                $display("%0t: point_x expected %0d actual %0d", $realtime, e.x, got.x);
                errors++;
            end
            if (got.y !== e.y) begin
                $display("%0t: point_y expected %0d actual %0d", $realtime, e.y, got.y);
                errors++;
            end
            if (got.z !== e.z) begin
                $display("%0t: point_z expected %0d actual %0d", $realtime, e.z, got.z);
                errors++;
            end
            if (got.range_mm !== e.range_mm) begin
                $display("%0t: range expected %0d actual %0d", $realtime, e.range_mm,
                         got.range_mm);
                errors++;
            end
            if (got.column !== e.column) begin
                $display("%0t: column expected %0d actual %0d", $realtime, e.column,
                         got.column);
                errors++;
            end
            if (got.row !== e.row) begin
                $display("%0t: row expected %0d actual %0d", $realtime, e.row, got.row);
                errors++;
            end
            if (got.last !== e.last) begin
                $display("%0t: frame_last expected %0b actual %0b", $realtime, e.last,
                         got.last);
                errors++;
            end
            if (got.near_mm !== e.near_mm) begin
                $display("%0t: min range expected %0d actual %0d", $realtime, e.near_mm,
                         got.near_mm);
                errors++;
            end
            if (got.far_mm !== e.far_mm) begin
                $display("%0t: max range expected %0d actual %0d", $realtime, e.far_mm,
                         got.far_mm);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic [15:0]          i_depth_mm;
    logic                 o_valid;
    logic                 i_ready;
    logic signed [19:0]   o_point_x;
    logic signed [19:0]   o_point_y;
    logic [15:0]          o_point_z;
    logic [19:0]          o_range_mm;
    logic [10:0]          o_pixel_column;
    logic [10:0]          o_pixel_row;
    logic                 o_frame_last;
    logic [19:0]          o_min_range_so_far;
    logic [19:0]          o_max_range_so_far;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]          i_cfg_data;

    range_scoreboard sb = new();

    depth_to_range_image dut (.*);

    always #4 i_clk = ~i_clk;

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_depth_mm  <= '0;
        i_ready     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Output side: a random stall before each word, sometimes none at all.
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = $urandom_range(0, 5);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    always @(posedge i_clk) begin
        t_point_word got;
        if (i_rst_n && o_valid && i_ready) begin
            got.x        = o_point_x;
            got.y        = o_point_y;
            got.z        = o_point_z;
            got.range_mm = o_range_mm;
            got.column   = o_pixel_column;
            got.row      = o_pixel_row;
            got.last     = o_frame_last;
            got.near_mm  = o_min_range_so_far;
            got.far_mm   = o_max_range_so_far;
            sb.check_point(got);
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)
                || !i_rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("depth_to_range_image test failed");
        $finish;
    end

    // Valid stays high across back-to-back words; this task drops it only for a drawn gap.
    task automatic send_depth(logic [15:0] d);
        int gap;
        gap = $urandom_range(0, 5);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_depth_mm <= d;
        do @(posedge i_clk); while (!o_ready);
        sb.note_depth(d);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic set_config(logic [31:0] w, logic [31:0] h, logic [31:0] cx,
                              logic [31:0] cy, logic [31:0] ifx, logic [31:0] ify);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_INV_FOCAL_X, ifx);
        write_reg(CFG_INV_FOCAL_Y, ify);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending_points.size() > 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_size();
        int mode;
        mode = $urandom_range(0, 9);
        case (mode)
            0: return 32'd0;
            1: return 32'hFFFF_F000 | 32'd4095;
            2: return $urandom;
            default: return $urandom_range(1, 12);
        endcase
    endfunction

    function automatic logic [15:0] pick_depth();
        int mode;
        mode = $urandom_range(0, 9);
        case (mode)
            0: return 16'd0;
            1: return 16'hFFFF;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] ifx;
        logic [31:0] ify;
        @(posedge i_clk iff i_rst_n);

        // Defaults straight after reset, with depth extremes and alternating bit patterns.
        send_depth(16'd0);
        send_depth(16'hFFFF);
        send_depth(16'd1);
        send_depth(16'h8000);
        send_depth(16'h5555);
        send_depth(16'hAAAA);
        drain();

        // Zero sizes act as one pixel per frame; full-scale focal terms saturate.
        set_config(32'd0, 32'd0, 32'hFFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_depth(16'hFFFF);
        send_depth(16'd0);
        send_depth(16'd1234);
        drain();

        // Oversized width clamps to the maximum; writes beyond the last index are ignored.
        set_config(32'hFFF, 32'd2, 32'd0, 32'd0, 32'd0, 32'd0);
        @(posedge i_clk);
        write_reg(3'd6, 32'hFFFF_FFFF);
        write_reg(3'd7, 32'h0000_0001);
        i_cfg_valid <= 1'b0;
        send_depth(16'hFFFF);
        send_depth(16'd77);
        drain();

        // Shrinking the width mid-frame ends the row at once.
        set_config(32'd8, 32'd4, 32'd40, 32'd24, 32'd8589934, 32'd8589934);
        repeat (5) send_depth(pick_depth());
        drain();
        set_config(32'd3, 32'd2, 32'd40, 32'd24, 32'd8589934, 32'd8589934);
        repeat (6) send_depth(pick_depth());
        drain();

        repeat (12) begin
            w   = pick_size();
            h   = pick_size();
            cx  = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 200);
            cy  = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 200);
            ifx = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1 << 20, 1 << 26);
            ify = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1 << 20, 1 << 26);
            set_config(w, h, cx, cy, ifx, ify);
            repeat (150) send_depth(pick_depth());
            drain();
        end

        if (sb.errors == 0)
            $display("depth_to_range_image test passed");
        else
            $display("depth_to_range_image test failed");
        $finish;
    end
endmodule
